[rtl/core/srtf_pkg.sv]
// Shared constants, controller state encoding and command/status structs
// for the SRTF batch scheduler. No dependencies.
`default_nettype none

package srtf_pkg;

  localparam int unsigned PROCS   = 16;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned ARR_W   = 12;
  localparam int unsigned BURST_W = 12;
  localparam int unsigned OUT_W   = 17;
  localparam int unsigned IDX_W   = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int unsigned CNT_W   = $clog2(PROCS + 1);
  localparam int unsigned TIME_W  = ARR_W + CNT_W;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_STEP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic sched_init;
    logic scan;
    logic step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic batch_end;
    logic scan_last;
    logic more_work;
    logic out_free;
    logic emit_last;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/srtf_ctrl.sv]
// Controller FSM: load, scan/step schedule loop, result emission.
// Depends on srtf_pkg.
`default_nettype none

module srtf_ctrl import srtf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.batch_end) begin
            cmd_o.sched_init = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = status_i.more_work ? ST_SCAN : ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_last) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/srtf_dp.sv]
// Datapath: arrival-sorted job tables, scan/select logic, time advance,
// and the result output register. Depends on srtf_pkg.
`default_nettype none

module srtf_dp import srtf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [ID_W-1:0]    job_id_i,
  input  logic [ARR_W-1:0]   arrival_time_i,
  input  logic [BURST_W-1:0] burst_length_i,
  input  logic               final_job_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [ID_W-1:0]    result_id_o,
  output logic [OUT_W-1:0]   completion_time_o,
  output logic [OUT_W-1:0]   turnaround_o,
  output logic [OUT_W-1:0]   waiting_o,
  output logic               last_result_o,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o
);

  logic [ID_W-1:0]    id_q    [PROCS];
  logic [ARR_W-1:0]   arr_q   [PROCS];
  logic [BURST_W-1:0] burst_q [PROCS];
  logic [BURST_W-1:0] rem_q   [PROCS];
  logic [TIME_W-1:0]  fin_q   [PROCS];

  logic [CNT_W-1:0]   n_q;
  logic [IDX_W-1:0]   idx_q;
  logic [TIME_W-1:0]  time_q;
  logic               found_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic [BURST_W-1:0] best_rem_q;
  logic               next_valid_q;
  logic [ARR_W-1:0]   next_arr_q;

  logic               out_valid_q;
  logic [ID_W-1:0]    res_id_q;
  logic [OUT_W-1:0]   comp_q;
  logic [OUT_W-1:0]   tat_q;
  logic [OUT_W-1:0]   wait_q;
  logic               last_q;

  // Sorted insert: entries with arrival <= new stay, the rest shift up one.
  logic [PROCS-1:0]   le;
  logic [PROCS-1:0]   ins_here;
  logic [ID_W-1:0]    sh_id    [PROCS];
  logic [ARR_W-1:0]   sh_arr   [PROCS];
  logic [BURST_W-1:0] sh_burst [PROCS];

  always_comb begin
    for (int k = 0; k < PROCS; k++) begin
      le[k] = (CNT_W'(k) < n_q) && (arr_q[k] <= arrival_time_i);
    end
    ins_here[0] = 1'b1;
    sh_id[0]    = job_id_i;
    sh_arr[0]   = arrival_time_i;
    sh_burst[0] = burst_length_i;
    for (int k = 1; k < PROCS; k++) begin
      ins_here[k] = le[k-1];
      sh_id[k]    = id_q[k-1];
      sh_arr[k]   = arr_q[k-1];
      sh_burst[k] = burst_q[k-1];
    end
  end

  // Entry at the shared index (scan and emit)
  logic [ID_W-1:0]    cur_id;
  logic [ARR_W-1:0]   cur_arr;
  logic [BURST_W-1:0] cur_burst;
  logic [BURST_W-1:0] cur_rem;
  logic [TIME_W-1:0]  cur_fin;
  logic               cur_arrived;
  logic               idx_last;

  assign cur_id      = id_q[idx_q];
  assign cur_arr     = arr_q[idx_q];
  assign cur_burst   = burst_q[idx_q];
  assign cur_rem     = rem_q[idx_q];
  assign cur_fin     = fin_q[idx_q];
  assign cur_arrived = TIME_W'(cur_arr) <= time_q;
  assign idx_last    = (CNT_W'(idx_q) + CNT_W'(1)) == n_q;

  // Run the selected job until it finishes or the next arrival may preempt.
  logic [TIME_W-1:0]  gap;
  logic               use_gap;
  logic [BURST_W-1:0] chunk;
  logic [BURST_W-1:0] new_rem;
  logic [TIME_W-1:0]  time_end;

  assign gap      = TIME_W'(next_arr_q) - time_q;
  assign use_gap  = next_valid_q && (gap < TIME_W'(best_rem_q));
  assign chunk    = use_gap ? gap[BURST_W-1:0] : best_rem_q;
  assign new_rem  = best_rem_q - chunk;
  assign time_end = time_q + TIME_W'(chunk);

  // Result arithmetic
  logic [TIME_W-1:0] e_comp;
  logic [TIME_W-1:0] e_tat;
  logic [TIME_W-1:0] e_wait;

  assign e_comp = (cur_burst == '0) ? TIME_W'(cur_arr) : cur_fin;
  assign e_tat  = e_comp - TIME_W'(cur_arr);
  assign e_wait = e_tat - TIME_W'(cur_burst);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < PROCS; k++) begin
        if (!le[k]) begin
          id_q[k]    <= ins_here[k] ? job_id_i : sh_id[k];
          arr_q[k]   <= ins_here[k] ? arrival_time_i : sh_arr[k];
          burst_q[k] <= ins_here[k] ? burst_length_i : sh_burst[k];
          rem_q[k]   <= ins_here[k] ? burst_length_i : sh_burst[k];
        end
      end
    end else if (cmd_i.step && found_q) begin
      rem_q[best_idx_q] <= new_rem;
      if (new_rem == '0) begin
        fin_q[best_idx_q] <= time_end;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && cur_rem != '0 && cur_arrived &&
        (!found_q || cur_rem < best_rem_q)) begin
      best_idx_q <= idx_q;
      best_rem_q <= cur_rem;
    end
    if (cmd_i.scan && cur_rem != '0 && !cur_arrived && !next_valid_q) begin
      next_arr_q <= cur_arr;
    end
    if (cmd_i.emit) begin
      res_id_q <= cur_id;
      comp_q   <= OUT_W'(e_comp);
      tat_q    <= OUT_W'(e_tat);
      wait_q   <= OUT_W'(e_wait);
      last_q   <= idx_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q          <= '0;
      idx_q        <= '0;
      time_q       <= '0;
      found_q      <= 1'b0;
      next_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        n_q <= n_q + CNT_W'(1);
      end
      if (cmd_i.sched_init) begin
        time_q       <= '0;
        idx_q        <= '0;
        found_q      <= 1'b0;
        next_valid_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        idx_q <= idx_q + IDX_W'(1);
        if (cur_rem != '0) begin
          if (cur_arrived) begin
            found_q <= 1'b1;
          end else begin
            next_valid_q <= 1'b1;
          end
        end
      end
      if (cmd_i.step) begin
        idx_q        <= '0;
        found_q      <= 1'b0;
        next_valid_q <= 1'b0;
        if (found_q) begin
          time_q <= time_end;
        end else if (next_valid_q) begin
          time_q <= TIME_W'(next_arr_q);
        end
      end
      if (cmd_i.emit) begin
        idx_q       <= idx_q + IDX_W'(1);
        out_valid_q <= 1'b1;
        if (idx_last) begin
          n_q <= '0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.batch_end = final_job_i || (n_q == CNT_W'(PROCS - 1));
  assign status_o.scan_last = idx_last;
  assign status_o.more_work = found_q || next_valid_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.emit_last = idx_last;

  assign out_valid_o       = out_valid_q;
  assign result_id_o       = res_id_q;
  assign completion_time_o = comp_q;
  assign turnaround_o      = tat_q;
  assign waiting_o         = wait_q;
  assign last_result_o     = last_q;

endmodule

`default_nettype wire

[rtl/core/srtf_batch_scheduler_core.sv]
// Jobs load one per cycle, while the core is loading, into an arrival-sorted table. After the last
// job the schedule runs in rounds of a table scan plus a step; a step runs the chosen job up to
// its finish or the next arrival, so at most 2n+1 rounds. Results then leave one per cycle from
// the output register while the receiver is ready. One batch is handled at a time. Reset (async,
// active low) returns to loading, table empty.
// Depends on srtf_pkg, srtf_ctrl, srtf_dp.
`default_nettype none

module srtf_batch_scheduler_core import srtf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ID_W-1:0]    job_id_i,
  input  logic [ARR_W-1:0]   arrival_time_i,
  input  logic [BURST_W-1:0] burst_length_i,
  input  logic               final_job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ID_W-1:0]    result_id_o,
  output logic [OUT_W-1:0]   completion_time_o,
  output logic [OUT_W-1:0]   turnaround_o,
  output logic [OUT_W-1:0]   waiting_o,
  output logic               last_result_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  srtf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srtf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_id_i          (job_id_i),
    .arrival_time_i    (arrival_time_i),
    .burst_length_i    (burst_length_i),
    .final_job_i       (final_job_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .result_id_o       (result_id_o),
    .completion_time_o (completion_time_o),
    .turnaround_o      (turnaround_o),
    .waiting_o         (waiting_o),
    .last_result_o     (last_result_o),
    .cmd_i             (cmd),
    .status_o          (status)
  );

endmodule

`default_nettype wire
